[src/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

[src/hsd_pkg.sv]
package hsd_pkg;

    localparam int X_W          = 12;
    localparam int TRAVEL_W     = 13;
    localparam int COUNT_W      = 16;
    localparam int REV_W        = 3;
    localparam int WINDOW_DEPTH = 6;
    localparam int HELD_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CFG_IDX_W    = 1;

    localparam logic [TRAVEL_W-1:0] TRAVEL_MAX       = {TRAVEL_W{1'b1}};
    localparam logic [X_W-1:0]      JUMP_LIMIT_RST   = X_W'(100);
    localparam logic [X_W-1:0]      THRESHOLD_RST    = X_W'(50);

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_ONE   = 2'd1,
        FILL_TWO   = 2'd2,
        FILL_MORE  = 2'd3
    } t_fill;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_JUMP_LIMIT      = 1'd0,
        REG_SWIPE_THRESHOLD = 1'd1
    } t_cfg_reg;

    // Window control from the tracker.
    typedef struct packed {
        logic push;
        logic restart;
    } t_win_ctl;

    // Window taps seen by the tracker.
    typedef struct packed {
        logic [X_W-1:0] prev;
        logic [X_W-1:0] oldest;
    } t_win_view;

    typedef struct packed {
        logic               fired;
        t_dir               dir;
        logic [COUNT_W-1:0] number;
    } t_result;

endpackage

[src/hsd_point_if.sv]
interface hsd_point_if;
    logic                   valid;
    logic                   ready;
    logic [hsd_pkg::X_W-1:0] x_position;

    modport source (output valid, output x_position, input ready);
    modport sink   (input valid, input x_position, output ready);
endinterface

[src/hsd_swipe_if.sv]
interface hsd_swipe_if;
    logic                       valid;
    logic                       ready;
    logic                       swipe_fired;
    logic [1:0]                 swipe_direction;
    logic [hsd_pkg::COUNT_W-1:0] swipe_number;

    modport source (output valid, output swipe_fired, output swipe_direction,
                    output swipe_number, input ready);
    modport sink   (input valid, input swipe_fired, input swipe_direction,
                    input swipe_number, output ready);
endinterface

[src/hsd_cfg_if.sv]
interface hsd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [hsd_pkg::CFG_IDX_W-1:0] index;
    logic [hsd_pkg::X_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/hsd_window.sv]
module hsd_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hsd_pkg::t_win_ctl  i_ctl,
    input  logic [hsd_pkg::X_W-1:0] i_x,
    output hsd_pkg::t_win_view o_view
);
    import hsd_pkg::*;

    logic [X_W-1:0]    r_pts [WINDOW_DEPTH];
    logic [HELD_W-1:0] r_held;
    logic [HELD_W-1:0] n_held;
    logic [IDX_W-1:0]  w_oldest_idx;

    // Oldest held point once the current point is shifted in, indexed in the
    // window as it stands now.
    always_comb begin
        if (r_held >= HELD_W'(WINDOW_DEPTH)) begin
            w_oldest_idx = IDX_W'(1);
        end else if (r_held < HELD_W'(2)) begin
            w_oldest_idx = IDX_W'(WINDOW_DEPTH - 1);
        end else begin
            w_oldest_idx = IDX_W'(HELD_W'(WINDOW_DEPTH) - r_held);
        end
    end

    assign o_view.prev   = r_pts[WINDOW_DEPTH-1];
    assign o_view.oldest = r_pts[w_oldest_idx];

    always_comb begin
        if (i_ctl.restart) begin
            n_held = HELD_W'(1);
        end else if (r_held < HELD_W'(WINDOW_DEPTH)) begin
            n_held = r_held + HELD_W'(1);
        end else begin
            n_held = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                r_pts[i] <= r_pts[i+1];
            end
            r_pts[WINDOW_DEPTH-1] <= i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_ctl.push) begin
            r_held <= n_held;
        end
    end

endmodule

[src/hsd_tracker.sv]
module hsd_tracker #(
    parameter int REVERSAL_LIMIT = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [hsd_pkg::X_W-1:0]     i_x,
    input  logic [hsd_pkg::X_W-1:0]     i_jump_limit,
    input  logic [hsd_pkg::X_W-1:0]     i_threshold,
    input  hsd_pkg::t_win_view          i_view,
    output hsd_pkg::t_win_ctl           o_ctl,
    output hsd_pkg::t_result            o_res
);
    import hsd_pkg::*;

    t_fill               r_fill,   n_fill;
    t_dir                r_dir,    n_dir;
    logic [TRAVEL_W-1:0] r_travel, n_travel;
    logic [REV_W-1:0]    r_rev,    n_rev;
    t_dir                r_rep,    n_rep;
    logic [COUNT_W-1:0]  r_total,  n_total;

    logic [X_W-1:0]      w_step;
    logic [X_W-1:0]      w_span;
    logic                w_along;
    logic [TRAVEL_W:0]   w_sum;
    logic [TRAVEL_W-1:0] w_sat;
    logic [REV_W-1:0]    w_rev_inc;
    logic                w_fired;
    logic                w_restart;

    assign w_step  = (i_view.prev > i_x) ? i_view.prev - i_x : i_x - i_view.prev;
    assign w_span  = (i_view.oldest > i_x) ? i_view.oldest - i_x : i_x - i_view.oldest;
    assign w_along = (r_dir == DIR_LEFT  && i_view.prev < i_x) ||
                     (r_dir == DIR_RIGHT && i_view.prev > i_x);
    assign w_sum   = {1'b0, r_travel} + (TRAVEL_W + 1)'(w_step);
    assign w_sat   = (w_sum > {1'b0, TRAVEL_MAX}) ? TRAVEL_MAX : w_sum[TRAVEL_W-1:0];
    assign w_rev_inc = r_rev + REV_W'(1);

    always_comb begin
        n_fill    = r_fill;
        n_dir     = r_dir;
        n_travel  = r_travel;
        n_rev     = r_rev;
        n_rep     = r_rep;
        n_total   = r_total;
        w_fired   = 1'b0;
        w_restart = 1'b0;
        case (r_fill)
            FILL_EMPTY: begin
                w_restart = 1'b1;
            end
            FILL_ONE: begin
                n_fill = FILL_TWO;
                n_dir  = (i_view.prev < i_x) ? DIR_LEFT : DIR_RIGHT;
                n_rev  = '0;
            end
            default: begin
                if (w_step > i_jump_limit) begin
                    w_restart = 1'b1;
                end else begin
                    n_fill = FILL_MORE;
                    if (w_along) begin
                        if (w_sat > TRAVEL_W'(i_threshold)) begin
                            n_rep    = r_dir;
                            n_total  = r_total + COUNT_W'(1);
                            n_travel = w_sat - TRAVEL_W'(i_threshold);
                            w_fired  = 1'b1;
                        end else begin
                            n_travel = w_sat;
                        end
                    end else if (w_rev_inc >= REV_W'(REVERSAL_LIMIT)) begin
                        // re-derive from the whole window
                        n_travel = TRAVEL_W'(w_span);
                        n_dir    = (i_view.oldest > i_x) ? DIR_RIGHT : DIR_LEFT;
                        n_rev    = '0;
                    end else begin
                        n_rev = w_rev_inc;
                    end
                end
            end
        endcase
        if (w_restart) begin
            n_fill   = FILL_ONE;
            n_dir    = DIR_NONE;
            n_travel = '0;
            n_rev    = '0;
            n_rep    = DIR_NONE;
            n_total  = COUNT_W'(1);
        end
    end

    assign o_ctl.push    = i_go;
    assign o_ctl.restart = w_restart;

    assign o_res.fired  = w_fired;
    assign o_res.dir    = n_rep;
    assign o_res.number = n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= FILL_EMPTY;
            r_dir    <= DIR_NONE;
            r_travel <= '0;
            r_rev    <= '0;
            r_rep    <= DIR_NONE;
            r_total  <= COUNT_W'(1);
        end else if (i_go) begin
            r_fill   <= n_fill;
            r_dir    <= n_dir;
            r_travel <= n_travel;
            r_rev    <= n_rev;
            r_rep    <= n_rep;
            r_total  <= n_total;
        end
    end

endmodule

[src/horizontal_swipe_detector.sv]
// Horizontal swipe detector.
// i_point carries one tracked x position per transaction; o_swipe returns one
// result per point: swipe_fired, the last reported direction (0 none, 1 left
// for rising x, 2 right) and the swipe number. i_cfg writes index 0 (jump
// limit) or index 1 (swipe threshold); it is always ready and should be used
// only while no point is in flight.
// A point accepted on i_point is held in the input register and then moves into
// the result register, which drives o_swipe. Throughput is one point per cycle
// while the receiver does not stall: the tracking state updates as the point
// moves from the input register into the result register.
// When the receiver stalls, the result register holds and the input register
// takes one more point; after that i_point.ready drops until o_swipe moves.
// Reset (synchronous, active low) empties both registers, clears tracking,
// sets the swipe number to 1 and loads jump limit 100 and threshold 50. The
// point window itself is not cleared; it is read only where it was filled.
module horizontal_swipe_detector #(
    parameter int REVERSAL_LIMIT = 5
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hsd_point_if.sink   i_point,
    hsd_cfg_if.sink     i_cfg,
    hsd_swipe_if.source o_swipe
);
    import hsd_pkg::*;

    `include "assert_macros.svh"

    logic           r_in_valid;
    logic [X_W-1:0] r_in_x;
    logic           r_out_valid;
    t_result        r_out;
    logic [X_W-1:0] r_jump_limit;
    logic [X_W-1:0] r_threshold;

    logic      w_adv;
    t_win_ctl  w_ctl;
    t_win_view w_view;
    t_result   w_res;

    assign w_adv         = r_in_valid && (!r_out_valid || o_swipe.ready);
    assign i_point.ready = !r_in_valid || w_adv;
    assign i_cfg.ready   = 1'b1;

    hsd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (r_in_x),
        .o_view  (w_view)
    );

    hsd_tracker #(
        .REVERSAL_LIMIT (REVERSAL_LIMIT)
    ) u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (w_adv),
        .i_x          (r_in_x),
        .i_jump_limit (r_jump_limit),
        .i_threshold  (r_threshold),
        .i_view       (w_view),
        .o_ctl        (w_ctl),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit <= JUMP_LIMIT_RST;
            r_threshold  <= THRESHOLD_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_JUMP_LIMIT:      r_jump_limit <= i_cfg.data;
                REG_SWIPE_THRESHOLD: r_threshold  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_point.ready) begin
            r_in_valid <= i_point.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_point.valid && i_point.ready) begin
            r_in_x <= i_point.x_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_swipe.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_swipe.valid           = r_out_valid;
    assign o_swipe.swipe_fired     = r_out.fired;
    assign o_swipe.swipe_direction = r_out.dir;
    assign o_swipe.swipe_number    = r_out.number;

    `ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    `ASSERT_NEXT(a_stall_holds_out, i_clk, i_rst_n, r_out_valid && !o_swipe.ready, r_out_valid)
    `ASSERT_IMPLIES(a_fire_has_dir, i_clk, i_rst_n, r_out_valid && r_out.fired, r_out.dir != DIR_NONE)
    `ASSERT_IMPLIES(a_restart_no_fire, i_clk, i_rst_n, w_adv && w_ctl.restart, !w_res.fired)

endmodule

[tb/sv/horizontal_swipe_detector_test.sv]
module horizontal_swipe_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hsd_pkg::*;

    localparam int REVERSAL_LIMIT = 5;
    localparam int LATENCY_SLACK  = 4;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int PHASE_POINTS   = 160;
    localparam int RANDOM_PHASES  = 10;
    localparam int PLAN_ROWS      = 23;
    localparam int SAW_POINTS     = 256;

    typedef enum int {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic           typed;
        t_result        res;
    } t_plan_row;

    localparam t_result FRESH     = '{fired: 1'b0, dir: DIR_NONE, number: 16'd1};
    localparam t_result PREDICTED = '0;

    // Hand-checked rows carry their result; the rest go through the tracker model.
    t_plan_row plan [PLAN_ROWS] = '{
        '{12'd0,    1'b1, FRESH},      // restart from empty
        '{12'd4095, 1'b1, FRESH},      // second point, full-scale step, no jump check
        '{12'd4095, 1'b1, FRESH},      // zero step counts as a reversal
        '{12'd4000, 1'b0, PREDICTED},
        '{12'd3900, 1'b0, PREDICTED},  // step equal to the jump limit
        '{12'd3899, 1'b0, PREDICTED},
        '{12'd3899, 1'b0, PREDICTED},  // fifth reversal: direction from window
        '{12'd3898, 1'b0, PREDICTED},
        '{12'd3848, 1'b0, PREDICTED},
        '{12'd3747, 1'b1, FRESH},      // one past the jump limit
        '{12'd3747, 1'b1, FRESH},      // equal second point gives right
        '{12'd3697, 1'b0, PREDICTED},  // travel equal to threshold
        '{12'd3696, 1'b0, PREDICTED},  // one above threshold
        '{12'd3697, 1'b0, PREDICTED},
        '{12'd3800, 1'b1, FRESH},
        '{12'd3801, 1'b1, FRESH},      // rising second point gives left
        '{12'd3901, 1'b0, PREDICTED},
        '{12'd4001, 1'b0, PREDICTED},
        '{12'd4095, 1'b0, PREDICTED},
        '{12'd4095, 1'b0, PREDICTED},
        '{12'd0,    1'b1, FRESH},
        '{12'd0,    1'b1, FRESH},
        '{12'd100,  1'b0, PREDICTED}
    };

    logic i_clk;
    logic i_rst_n;

    hsd_point_if point_ch ();
    hsd_cfg_if   cfg_ch ();
    hsd_swipe_if swipe_ch ();

    horizontal_swipe_detector #(
        .REVERSAL_LIMIT(REVERSAL_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (point_ch),
        .i_cfg   (cfg_ch),
        .o_swipe (swipe_ch)
    );

    // Tracker model state.
    logic [X_W-1:0]      window_x [WINDOW_DEPTH];
    int                  held;
    t_fill               fill;
    t_dir                heading_dir;
    logic [TRAVEL_W-1:0] travel;
    logic [REV_W-1:0]    reversals;
    t_dir                reported;
    logic [COUNT_W-1:0]  swipe_count;
    logic [X_W-1:0]      jump_limit;
    logic [X_W-1:0]      swipe_threshold;

    t_result expected_swipes [$];

    int send_idle_pct;
    int stall_pct;
    int errors;
    int points_sent;
    int results_checked;
    int swipes_seen;
    int settings_used;
    int cycles;

    function automatic void push_window(input logic [X_W-1:0] x);
        for (int i = 0; i + 1 < WINDOW_DEPTH; i++) begin
            window_x[i] = window_x[i+1];
        end
        window_x[WINDOW_DEPTH-1] = x;
        if (held < WINDOW_DEPTH) held++;
        if (fill != FILL_MORE) fill = t_fill'(fill + 2'd1);
    endfunction

    function automatic void restart_track(input logic [X_W-1:0] x);
        heading_dir = DIR_NONE;
        travel      = '0;
        reversals   = '0;
        reported    = DIR_NONE;
        swipe_count = 16'd1;
        held        = 0;
        fill        = FILL_EMPTY;
        push_window(x);
    endfunction

    function automatic t_result track_point(input logic [X_W-1:0] x);
        t_result        r;
        int             prev;
        int             oldest;
        int             step_size;
        int             sum;
        logic           along;
        r.fired = 1'b0;
        if (fill == FILL_EMPTY) begin
            restart_track(x);
        end else begin
            prev = int'(window_x[WINDOW_DEPTH-1]);
            step_size = (prev > int'(x)) ? prev - int'(x) : int'(x) - prev;
            if (fill == FILL_ONE) begin
                push_window(x);
                heading_dir = (prev < int'(x)) ? DIR_LEFT : DIR_RIGHT;
                reversals   = '0;
            end else if (step_size > int'(jump_limit)) begin
                restart_track(x);
            end else begin
                along = (heading_dir == DIR_LEFT && prev < int'(x)) ||
                        (heading_dir == DIR_RIGHT && prev > int'(x));
                push_window(x);
                if (along) begin
                    sum = int'(travel) + step_size;
                    if (sum > int'(TRAVEL_MAX)) sum = int'(TRAVEL_MAX);
                    if (sum > int'(swipe_threshold)) begin
                        reported    = heading_dir;
                        swipe_count = swipe_count + 16'd1;
                        sum         = sum - int'(swipe_threshold);
                        r.fired     = 1'b1;
                    end
                    travel = TRAVEL_W'(sum);
                end else begin
                    reversals = reversals + 3'd1;
                    if (int'(reversals) >= REVERSAL_LIMIT) begin
                        // Re-derive from the oldest held point.
                        oldest      = int'(window_x[WINDOW_DEPTH-held]);
                        travel      = TRAVEL_W'((oldest > int'(x)) ? oldest - int'(x)
                                                                   : int'(x) - oldest);
                        heading_dir = (oldest > int'(x)) ? DIR_RIGHT : DIR_LEFT;
                        reversals   = '0;
                    end
                end
            end
        end
        r.dir    = reported;
        r.number = swipe_count;
        return r;
    endfunction

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FULL: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            PACE_SEND_IDLE: begin
                send_idle_pct = 64;
                stall_pct     = 0;
            end
            PACE_RECV_STALL: begin
                send_idle_pct = 0;
                stall_pct     = 64;
            end
            default: begin
                send_idle_pct = 14;
                stall_pct     = 14;
            end
        endcase
    endtask

    task automatic send_point(input logic [X_W-1:0] x, input logic typed,
                              input t_result res);
        int      gap;
        t_result pred;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        point_ch.valid      <= 1'b1;
        point_ch.x_position <= x;
        do @(posedge i_clk); while (!point_ch.ready);
        pred = track_point(x);
        expected_swipes.insert(expected_swipes.size(), typed ? res : pred);
        points_sent++;
    endtask

    // Hold the sender until every result is back, then let the pipe settle.
    task automatic drain_points();
        @(negedge i_clk);
        point_ch.valid <= 1'b0;
        while (expected_swipes.size() != 0) @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [X_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == REG_JUMP_LIMIT) jump_limit = value;
        else swipe_threshold = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input logic [X_W-1:0] jump, input logic [X_W-1:0] thr);
        write_reg(REG_JUMP_LIMIT, jump);
        write_reg(REG_SWIPE_THRESHOLD, thr);
        settings_used++;
    endtask

    // Mostly gestures moving one way with steps inside the jump limit,
    // mixed with wiggles, boundary steps, jumps and scattered noise.
    task automatic random_points(input int count);
        int x;
        int heading;
        int span;
        int r;
        x       = $urandom_range(4095);
        heading = $urandom_range(1) ? 1 : -1;
        for (int n = 0; n < count; n++) begin
            r    = $urandom_range(99);
            span = ($urandom_range(3) == 0) ? int'(jump_limit) : int'(jump_limit) / 8;
            if (r < 4) begin
                x = $urandom_range(4095);
            end else if (r < 8) begin
                x = x + heading * (int'(jump_limit) + 1);
            end else if (r < 14) begin
                x = x + heading * int'(jump_limit);
            end else if (r < 24) begin
                x = x - heading * int'($urandom_range(0, span));
            end else begin
                x = x + heading * int'($urandom_range(1, (span > 1) ? span : 1));
            end
            if (x > 4095) begin
                x       = 4095;
                heading = -1;
            end else if (x < 0) begin
                x       = 0;
                heading = 1;
            end
            if ($urandom_range(29) == 0) heading = -heading;
            if ($urandom_range(199) == 0) drain_points();
            send_point(X_W'(x), 1'b0, PREDICTED);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        swipe_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            swipe_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && swipe_ch.valid && swipe_ch.ready) begin
                if (expected_swipes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual %0d/%0d/%0d",
                             $time, swipe_ch.swipe_fired, swipe_ch.swipe_direction,
                             swipe_ch.swipe_number);
                end else begin
                    want = expected_swipes.pop_front();
                    check_field("swipe_fired", want.fired, swipe_ch.swipe_fired);
                    check_field("swipe_direction", want.dir, swipe_ch.swipe_direction);
                    check_field("swipe_number", want.number, swipe_ch.swipe_number);
                    results_checked++;
                    if (swipe_ch.swipe_fired) swipes_seen++;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [X_W-1:0] jump_set [6] = '{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd300, 12'd64};
        logic [X_W-1:0] thr_set  [6] = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd200, 12'd40};
        int             k;

        i_rst_n             = 1'b0;
        point_ch.valid      = 1'b0;
        point_ch.x_position = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_JUMP_LIMIT;
        cfg_ch.data         = '0;
        errors              = 0;
        points_sent         = 0;
        results_checked     = 0;
        swipes_seen         = 0;
        settings_used       = 1;
        jump_limit          = JUMP_LIMIT_RST;
        swipe_threshold     = THRESHOLD_RST;
        for (int i = 0; i < WINDOW_DEPTH; i++) window_x[i] = '0;
        held        = 0;
        fill        = FILL_EMPTY;
        heading_dir = DIR_NONE;
        travel      = '0;
        reversals   = '0;
        reported    = DIR_NONE;
        swipe_count = 16'd1;
        set_pace(PACE_FULL);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) send_point(plan[i].x, plan[i].typed, plan[i].res);
        drain_points();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 6) configure(jump_set[p], thr_set[p]);
            else configure(X_W'($urandom_range(4095)), X_W'($urandom_range(4095)));
            set_pace(t_pace'(p % 4));
            random_points(PHASE_POINTS);
            drain_points();
        end

        // Sawtooth at zero threshold: nearly every rising step fires and the
        // travel runs into saturation.
        configure(12'd4095, 12'd0);
        set_pace(PACE_FULL);
        k = 0;
        repeat (SAW_POINTS) begin
            send_point(X_W'(k * 64), 1'b0, PREDICTED);
            k++;
        end
        drain_points();

        $display("covered %0d points under %0d register settings, %0d results checked",
                 points_sent, settings_used, results_checked);
        $display("%0d swipes reported across all pacing phases, mismatches: %0d",
                 swipes_seen, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
